### src/csr_sor_smoother_core_defines.svh
// Assertion helpers for the smoother RTL.
`ifndef CSR_SOR_SMOOTHER_CORE_DEFINES_SVH
`define CSR_SOR_SMOOTHER_CORE_DEFINES_SVH

// Check that a property holds at every clock edge, outside reset.
`define CSR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CSR_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

`endif

### src/csr_pkg.sv
package csr_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_NONZEROS = 8192;
  localparam int VAL_W        = 32;
  localparam int FRAC_W       = 16;
  localparam int OMEGA_FRAC   = 14;
  localparam int ROW_AW       = 10;  // index into rhs and solution
  localparam int RS_AW        = 11;  // index into row starts (MAX_ROWS+1 entries)
  localparam int NZ_AW        = 13;  // index into nonzeros
  localparam int RS_W         = 14;  // row start offset
  localparam int COL_W        = 10;
  localparam int DVD_W        = VAL_W + FRAC_W;

  localparam logic [2:0] CMD_ROW_START = 3'd0;
  localparam logic [2:0] CMD_NONZERO   = 3'd1;
  localparam logic [2:0] CMD_RHS       = 3'd2;
  localparam logic [2:0] CMD_SOL_WRITE = 3'd3;
  localparam logic [2:0] CMD_RUN       = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [2:0] REG_OMEGA     = 3'd0;
  localparam logic [2:0] REG_FIRST_ROW = 3'd1;
  localparam logic [2:0] REG_LAST_ROW  = 3'd2;
  localparam logic [2:0] REG_ROW_STEP  = 3'd3;
  localparam logic [2:0] REG_SWEEPS    = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;

  typedef struct packed {
    logic               rs_we;
    logic               nz_we;
    logic               rhs_we;
    logic               sol_we;
    logic [NZ_AW-1:0]   addr;
    logic [COL_W-1:0]   col;
    logic [VAL_W-1:0]   data;
  } csr_wr_t;

  typedef struct packed {
    logic [RS_AW-1:0]  rs_addr;
    logic [NZ_AW-1:0]  nz_addr;
    logic [ROW_AW-1:0] rhs_addr;
    logic [ROW_AW-1:0] sol_addr;
  } csr_rd_t;

  typedef struct packed {
    logic [RS_W-1:0]  rs;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] coef;
    logic [VAL_W-1:0] rhs;
    logic [VAL_W-1:0] sol;
  } csr_rdata_t;

  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] v;
  } sat_t;

  function automatic sat_t sat_val(input logic signed [63:0] x);
    sat_t r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    r.ovf = 1'b0;
    if (x > hi) begin
      r.ovf = 1'b1;
      r.v   = hi[VAL_W-1:0];
    end else if (x < lo) begin
      r.ovf = 1'b1;
      r.v   = lo[VAL_W-1:0];
    end else begin
      r.v = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/csr_store.sv
module csr_store
  import csr_pkg::*;
(
  input  logic       clk,
  input  csr_wr_t    wr,
  input  csr_rd_t    rd,
  output csr_rdata_t rdata
);

  logic [RS_W-1:0]        rs_mem  [0:MAX_ROWS];
  logic [COL_W+VAL_W-1:0] nz_mem  [0:MAX_NONZEROS-1];
  logic [VAL_W-1:0]       rhs_mem [0:MAX_ROWS-1];
  logic [VAL_W-1:0]       sol_mem [0:MAX_ROWS-1];

  always_ff @(posedge clk) begin
    if (wr.rs_we) begin
      rs_mem[wr.addr[RS_AW-1:0]] <= wr.data[RS_W-1:0];
    end
    if (wr.nz_we) begin
      nz_mem[wr.addr] <= {wr.col, wr.data};
    end
    if (wr.rhs_we) begin
      rhs_mem[wr.addr[ROW_AW-1:0]] <= wr.data;
    end
    if (wr.sol_we) begin
      sol_mem[wr.addr[ROW_AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata.rs                 <= rs_mem[rd.rs_addr];
    {rdata.col, rdata.coef}  <= nz_mem[rd.nz_addr];
    rdata.rhs                <= rhs_mem[rd.rhs_addr];
    rdata.sol                <= sol_mem[rd.sol_addr];
  end

endmodule

### src/csr_div.sv
module csr_div
  import csr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [VAL_W-1:0] dvs_r, dvs_nxt;
  logic [VAL_W:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem_r, dq_r[DVD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DVD_W);
      rem_nxt = '0;
      dq_nxt  = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      // one quotient bit per cycle, restoring
      rem_nxt = fits ? VAL_W'(trial - {1'b0, dvs_r}) : trial[VAL_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

### src/csr_sor_smoother_core.sv
// Channel      | Signals                                          | Transfer
// -------------+--------------------------------------------------+------------------------------
// request in   | start, busy, in_command/address/column/value     | start high while busy low
// result out   | out_valid, out_kind/result_value/saturated       | one cycle, cannot be stalled
// config       | psel, penable, pwrite, paddr, pwdata, prdata     | APB access phase, no waits
//
// Loads keep busy low; a read returns its result the cycle after.
// A run holds busy high until its finish result: each visited row reads its row starts,
// walks its nonzeros (a multiply and accumulate per off-diagonal one), and when the row
// updates, waits on the bit-serial divider, then writes the update; a row check ends each sweep.
// Reset is synchronous and clears control and configuration; stores hold garbage until loaded.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
`include "csr_sor_smoother_core_defines.svh"

module csr_sor_smoother_core
  import csr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_command,
  input  logic [13:0]             in_address,
  input  logic [COL_W-1:0]        in_column,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic                    out_saturated,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RUN_INIT = 4'd1;
  localparam logic [3:0] S_ROW_CHK  = 4'd2;
  localparam logic [3:0] S_ROW_RS1  = 4'd3;
  localparam logic [3:0] S_ROW_RS2  = 4'd4;
  localparam logic [3:0] S_NZ_CHK   = 4'd5;
  localparam logic [3:0] S_NZ_COL   = 4'd6;
  localparam logic [3:0] S_NZ_MUL   = 4'd7;
  localparam logic [3:0] S_NZ_ACC   = 4'd8;
  localparam logic [3:0] S_ROW_DIAG = 4'd9;
  localparam logic [3:0] S_DIV_WAIT = 4'd10;
  localparam logic [3:0] S_UPD1     = 4'd11;
  localparam logic [3:0] S_UPD2     = 4'd12;
  localparam logic [3:0] S_UPD3     = 4'd13;
  localparam logic [3:0] S_ROW_NEXT = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  localparam logic [RS_W-1:0] NZ_LIMIT = RS_W'(MAX_NONZEROS);

  // configuration registers
  logic [14:0] omega_r;
  logic [9:0]  first_row_r;
  logic [9:0]  last_row_r;
  logic [5:0]  row_step_r;
  logic [7:0]  sweep_count_r;
  logic [15:0] threshold_r;

  logic [3:0]              state_r, state_nxt;
  logic signed [11:0]      i_r, i_nxt;
  logic [7:0]              sweeps_r, sweeps_nxt;
  logic [RS_W-1:0]         k_r, k_nxt;
  logic [RS_W-1:0]         end_r, end_nxt;
  logic signed [VAL_W-1:0] t_r, t_nxt;
  logic signed [VAL_W-1:0] u_r, u_nxt;
  logic signed [VAL_W-1:0] d_r, d_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;
  logic signed [VAL_W-1:0] q_r, q_nxt;
  logic                    have_r, have_nxt;
  logic                    sat_r, sat_nxt;
  logic signed [63:0]      prod_r, prod_nxt;
  logic signed [63:0]      m1_r, m1_nxt;
  logic signed [63:0]      m2_r, m2_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    rd_ok_r, rd_ok_nxt;
  logic                    fin_r, fin_nxt;

  csr_wr_t    wr;
  csr_rd_t    rd;
  csr_rdata_t rdata;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [VAL_W-1:0] t_mag;
  logic [VAL_W-1:0] d_mag;

  logic               accept;
  logic               cfg_wr;
  logic signed [11:0] step_ext;
  logic signed [11:0] last_ext;
  logic               row_more;
  logic [RS_W-1:0]    rs_clamped;
  logic signed [63:0] diff;
  logic signed [63:0] qs;
  logic signed [63:0] upd;
  logic signed [16:0] w_comp;
  sat_t               t_sat;
  sat_t               q_sat;
  sat_t               u_sat;

  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign step_ext = 12'(signed'(row_step_r));
  assign last_ext = signed'({2'b00, last_row_r});
  assign row_more = row_step_r[5] ? (i_r >= last_ext) : (i_r <= last_ext);
  assign rs_clamped = (rdata.rs > NZ_LIMIT) ? NZ_LIMIT : rdata.rs;

  assign t_mag  = t_r[VAL_W-1] ? VAL_W'(-t_r) : VAL_W'(t_r);
  assign d_mag  = d_r[VAL_W-1] ? VAL_W'(-d_r) : VAL_W'(d_r);
  assign w_comp = 17'sd16384 - signed'({2'b00, omega_r});

  assign diff  = 64'(t_r) - (prod_r >>> FRAC_W);
  assign t_sat = sat_val(diff);
  assign qs    = (t_r[VAL_W-1] ^ d_r[VAL_W-1]) ? -signed'(64'(div_quo)) : signed'(64'(div_quo));
  assign q_sat = sat_val(qs);
  assign upd   = (m1_r + m2_r + 64'sd8192) >>> OMEGA_FRAC;
  assign u_sat = sat_val(upd);

  csr_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  csr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({t_mag, {FRAC_W{1'b0}}}),
    .divisor  (d_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  // request decode, run sequencer
  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    sweeps_nxt  = sweeps_r;
    k_nxt       = k_r;
    end_nxt     = end_r;
    t_nxt       = t_r;
    u_nxt       = u_r;
    d_nxt       = d_r;
    a_nxt       = a_r;
    q_nxt       = q_r;
    have_nxt    = have_r;
    sat_nxt     = sat_r;
    prod_nxt    = prod_r;
    m1_nxt      = m1_r;
    m2_nxt      = m2_r;
    rd_pend_nxt = 1'b0;
    rd_ok_nxt   = rd_ok_r;
    fin_nxt     = 1'b0;
    div_start   = 1'b0;

    wr        = '0;
    wr.addr   = in_address[NZ_AW-1:0];
    wr.col    = in_column;
    wr.data   = in_value;
    rd        = '0;
    rd.sol_addr = in_address[ROW_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_ROW_START: wr.rs_we  = in_address <= 14'(MAX_ROWS);
            CMD_NONZERO:   wr.nz_we  = !in_address[13];
            CMD_RHS:       wr.rhs_we = in_address[13:ROW_AW] == '0;
            CMD_SOL_WRITE: wr.sol_we = in_address[13:ROW_AW] == '0;
            CMD_RUN: begin
              sat_nxt   = 1'b0;
              state_nxt = S_RUN_INIT;
            end
            CMD_READ: begin
              rd_pend_nxt = 1'b1;
              rd_ok_nxt   = in_address[13:ROW_AW] == '0;
            end
            default: ;
          endcase
        end
      end
      S_RUN_INIT: begin
        sweeps_nxt = sweep_count_r;
        i_nxt      = signed'({2'b00, first_row_r});
        state_nxt  = (row_step_r == '0 || sweep_count_r == '0) ? S_DONE : S_ROW_CHK;
      end
      S_ROW_CHK: begin
        rd.rs_addr  = RS_AW'(i_r[ROW_AW-1:0]);
        rd.rhs_addr = i_r[ROW_AW-1:0];
        rd.sol_addr = i_r[ROW_AW-1:0];
        if (!row_more) begin
          // sweep finished: start the next one or report
          sweeps_nxt = sweeps_r - 1'b1;
          i_nxt      = signed'({2'b00, first_row_r});
          if (sweeps_r == 8'd1) begin
            state_nxt = S_DONE;
          end
        end else if (i_r < 12'sd1024) begin
          state_nxt = S_ROW_RS1;
        end else begin
          i_nxt = i_r + step_ext;
        end
      end
      S_ROW_RS1: begin
        k_nxt       = rs_clamped;
        t_nxt       = rdata.rhs;
        u_nxt       = rdata.sol;
        have_nxt    = 1'b0;
        rd.rs_addr  = RS_AW'(i_r[ROW_AW-1:0]) + 1'b1;
        state_nxt   = S_ROW_RS2;
      end
      S_ROW_RS2: begin
        end_nxt   = rs_clamped;
        state_nxt = S_NZ_CHK;
      end
      S_NZ_CHK: begin
        rd.nz_addr = k_r[NZ_AW-1:0];
        state_nxt  = (k_r < end_r) ? S_NZ_COL : S_ROW_DIAG;
      end
      S_NZ_COL: begin
        rd.sol_addr = rdata.col;
        if (rdata.col == i_r[ROW_AW-1:0]) begin
          // diagonal: keep the last one seen
          d_nxt     = rdata.coef;
          have_nxt  = 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_NZ_CHK;
        end else begin
          a_nxt     = rdata.coef;
          state_nxt = S_NZ_MUL;
        end
      end
      S_NZ_MUL: begin
        prod_nxt  = 64'(a_r) * 64'(signed'(rdata.sol));
        state_nxt = S_NZ_ACC;
      end
      S_NZ_ACC: begin
        t_nxt     = t_sat.v;
        sat_nxt   = sat_r | t_sat.ovf;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_NZ_CHK;
      end
      S_ROW_DIAG: begin
        if (have_r && (d_mag > {16'd0, threshold_r})) begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end else begin
          state_nxt = S_ROW_NEXT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          q_nxt     = q_sat.v;
          sat_nxt   = sat_r | q_sat.ovf;
          state_nxt = S_UPD1;
        end
      end
      S_UPD1: begin
        m1_nxt    = 64'(signed'({1'b0, omega_r})) * 64'(q_r);
        state_nxt = S_UPD2;
      end
      S_UPD2: begin
        m2_nxt    = 64'(w_comp) * 64'(u_r);
        state_nxt = S_UPD3;
      end
      S_UPD3: begin
        wr.sol_we = 1'b1;
        wr.addr   = NZ_AW'(i_r[ROW_AW-1:0]);
        wr.data   = u_sat.v;
        sat_nxt   = sat_r | u_sat.ovf;
        state_nxt = S_ROW_NEXT;
      end
      S_ROW_NEXT: begin
        i_nxt     = i_r + step_ext;
        state_nxt = S_ROW_CHK;
      end
      S_DONE: begin
        fin_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sat_r     <= 1'b0;
      rd_pend_r <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sat_r     <= sat_nxt;
      rd_pend_r <= rd_pend_nxt;
      fin_r     <= fin_nxt;
    end
    i_r      <= i_nxt;
    sweeps_r <= sweeps_nxt;
    k_r      <= k_nxt;
    end_r    <= end_nxt;
    t_r      <= t_nxt;
    u_r      <= u_nxt;
    d_r      <= d_nxt;
    a_r      <= a_nxt;
    q_r      <= q_nxt;
    have_r   <= have_nxt;
    prod_r   <= prod_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  // configuration registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r       <= 15'd16384;
      first_row_r   <= 10'd0;
      last_row_r    <= 10'd1023;
      row_step_r    <= 6'd1;
      sweep_count_r <= 8'd1;
      threshold_r   <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_OMEGA:     omega_r       <= pwdata[14:0];
        REG_FIRST_ROW: first_row_r   <= pwdata[9:0];
        REG_LAST_ROW:  last_row_r    <= pwdata[9:0];
        REG_ROW_STEP:  row_step_r    <= pwdata[5:0];
        REG_SWEEPS:    sweep_count_r <= pwdata[7:0];
        REG_THRESHOLD: threshold_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_OMEGA:     prdata = {17'd0, omega_r};
      REG_FIRST_ROW: prdata = {22'd0, first_row_r};
      REG_LAST_ROW:  prdata = {22'd0, last_row_r};
      REG_ROW_STEP:  prdata = {{26{row_step_r[5]}}, row_step_r};
      REG_SWEEPS:    prdata = {24'd0, sweep_count_r};
      REG_THRESHOLD: prdata = {16'd0, threshold_r};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = state_r != S_IDLE;

  // read data comes straight off the registered memory port
  assign out_valid        = rd_pend_r | fin_r;
  assign out_kind         = fin_r;
  assign out_result_value = (rd_pend_r && rd_ok_r) ? signed'(rdata.sol) : '0;
  assign out_saturated    = fin_r & sat_r;

  `CSR_CHECK(a_one_result, !(rd_pend_r && fin_r), "read and finish results collide")
  `CSR_IMPLY(a_sol_wr_src, wr.sol_we && busy, state_r == S_UPD3,
             "solution written outside the update step")
  `CSR_IMPLY(a_fin_after_done, fin_r, $past(state_r) == S_DONE,
             "finish result without a completed run")
  `CSR_IMPLY(a_div_idle, div_done, state_r == S_DIV_WAIT,
             "divider finished while nobody waits")

endmodule
